// ===== rtl/received_range_merge_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// received range merge tracker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RECEIVED_RANGE_MERGE_TRACKER_UNIT_DEFINES_SVH
`define RECEIVED_RANGE_MERGE_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RRMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrmt_pkg
// types and constants shared by the range merge tracker and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package rrmt_pkg;

  localparam int DEF_MAX_RANGES  = 16;
  localparam int DEF_OFFSET_BITS = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int STATUS_W        = 2;
  localparam int EXP_END_RESET   = 999;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXP_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXP_END   = CFG_IDX_W'(1);

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_DROPPED  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_REJECTED = STATUS_W'(2);

  // per-cell operation
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MERGE,
    OP_LEFT,
    OP_RIGHT,
    OP_ABSORB
  } cell_op_t;

  // per-cell compare results against the packet and the left neighbour
  typedef struct packed {
    logic below;
    logic merge;
    logic touch_left;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/rrmt_cell.sv =====
// ----------------------------------------------------------------------------
// rrmt_cell
// one table entry: holds a range, compares it, takes data from its neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module rrmt_cell
  import rrmt_pkg::*;
#(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  wire logic                   clk,
  input  wire cell_op_t               op,
  input  wire logic                   valid,
  input  wire logic [OFFSET_BITS-1:0] pkt_start,
  input  wire logic [OFFSET_BITS-1:0] pkt_end,
  input  wire logic [OFFSET_BITS-1:0] left_start,
  input  wire logic [OFFSET_BITS-1:0] left_end,
  input  wire logic [OFFSET_BITS-1:0] right_start,
  input  wire logic [OFFSET_BITS-1:0] right_end,
  output logic      [OFFSET_BITS-1:0] rng_start,
  output logic      [OFFSET_BITS-1:0] rng_end,
  output cell_flags_t                 flags
);

  // end plus one is taken one bit wider so an all-ones end does not wrap to zero
  logic [OFFSET_BITS:0] end_p1;
  logic [OFFSET_BITS:0] pkt_end_p1;
  logic [OFFSET_BITS:0] left_end_p1;

  assign end_p1      = {1'b0, rng_end}  + (OFFSET_BITS + 1)'(1);
  assign pkt_end_p1  = {1'b0, pkt_end}  + (OFFSET_BITS + 1)'(1);
  assign left_end_p1 = {1'b0, left_end} + (OFFSET_BITS + 1)'(1);

  always_comb begin
    flags.below      = valid && (end_p1 < {1'b0, pkt_start});
    flags.merge      = valid && !flags.below && ({1'b0, rng_start} <= pkt_end_p1);
    flags.touch_left = valid && ({1'b0, rng_start} <= left_end_p1);
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        rng_start <= pkt_start;
        rng_end   <= pkt_end;
      end
      OP_MERGE: begin
        if (pkt_start < rng_start) begin
          rng_start <= pkt_start;
        end
        if (pkt_end > rng_end) begin
          rng_end <= pkt_end;
        end
      end
      OP_LEFT: begin
        rng_start <= left_start;
        rng_end   <= left_end;
      end
      OP_RIGHT: begin
        rng_start <= right_start;
        rng_end   <= right_end;
      end
      OP_ABSORB: begin
        if (right_end > rng_end) begin
          rng_end <= right_end;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/received_range_merge_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// received_range_merge_tracker_unit
// sorted table of disjoint received ranges held in a chain of cells
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy is low; its single result is
// shown on status, range_count and complete for exactly one cycle with
// result_valid high, and the receiver cannot stall it. A reversed packet
// gives its result on the cycle after it is taken. Otherwise a parallel
// compare in every cell (S_CMP) decides merge, insert or drop, and the result
// shows in S_REPORT; busy holds off packets only in S_CMP and S_COLLAPSE.
// When the grown range reaches further stored ranges, each one is absorbed by
// a one-place shift through the cell chain in S_COLLAPSE. Configuration
// writes are always ready and are registered whenever cfg_valid is high.
`default_nettype none

module received_range_merge_tracker_unit
  import rrmt_pkg::*;
#(
  parameter int MAX_RANGES  = DEF_MAX_RANGES,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  localparam int CNT_W      = $clog2(MAX_RANGES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [OFFSET_BITS-1:0] pkt_start,
  input  wire logic [OFFSET_BITS-1:0] pkt_end,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [OFFSET_BITS-1:0] cfg_data,
  output logic                        result_valid,
  output logic      [STATUS_W-1:0]    status,
  output logic      [CNT_W-1:0]       range_count,
  output logic                        complete
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COLLAPSE,
    S_REPORT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [OFFSET_BITS-1:0]   ps_q;
  logic [OFFSET_BITS-1:0]   pe_q;
  logic [MAX_RANGES-1:0]    pos_oh;
  logic [MAX_RANGES-1:0]    above_q;
  logic [STATUS_W-1:0]      status_q;
  logic [OFFSET_BITS-1:0]   exp_start;
  logic [OFFSET_BITS-1:0]   exp_end;

  logic [OFFSET_BITS-1:0]   cell_start [MAX_RANGES];
  logic [OFFSET_BITS-1:0]   cell_end   [MAX_RANGES];
  cell_flags_t              cell_flags [MAX_RANGES];
  cell_op_t                 cell_op    [MAX_RANGES];

  logic [MAX_RANGES-1:0]    before_vec;
  logic [MAX_RANGES-1:0]    merge_vec;
  logic [MAX_RANGES-1:0]    touch_vec;
  logic [MAX_RANGES-1:0]    pos_oh_c;
  logic                     hit;
  logic                     more;
  logic                     absorb;
  logic                     full;
  logic                     accept;

  // ---- cell chain ----
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic [OFFSET_BITS-1:0] l_start;
    logic [OFFSET_BITS-1:0] l_end;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_end;

    if (i == 0) begin : g_first
      assign l_start = '0;
      assign l_end   = '0;
    end else begin : g_mid_l
      assign l_start = cell_start[i-1];
      assign l_end   = cell_end[i-1];
    end

    if (i == MAX_RANGES - 1) begin : g_last
      assign r_start = '0;
      assign r_end   = '0;
    end else begin : g_mid_r
      assign r_start = cell_start[i+1];
      assign r_end   = cell_end[i+1];
    end

    rrmt_cell #(
      .OFFSET_BITS (OFFSET_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op[i]),
      .valid       (CNT_W'(i) < count),
      .pkt_start   (ps_q),
      .pkt_end     (pe_q),
      .left_start  (l_start),
      .left_end    (l_end),
      .right_start (r_start),
      .right_end   (r_end),
      .rng_start   (cell_start[i]),
      .rng_end     (cell_end[i]),
      .flags       (cell_flags[i])
    );
  end

  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      before_vec[i] = cell_flags[i].below;
      merge_vec[i]  = cell_flags[i].merge;
      touch_vec[i]  = cell_flags[i].touch_left;
    end
  end

  // insert position: first cell not lying wholly below the packet
  assign pos_oh_c = ~before_vec & {before_vec[MAX_RANGES-2:0], 1'b1};
  assign hit      = |(pos_oh_c & merge_vec);
  assign more     = |(pos_oh_c & {1'b0, merge_vec[MAX_RANGES-1:1]});
  assign absorb   = |(pos_oh & {1'b0, touch_vec[MAX_RANGES-1:1]});
  assign full     = (count == CNT_W'(MAX_RANGES));

  assign busy      = (state == S_CMP) || (state == S_COLLAPSE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      cell_op[i] = OP_HOLD;
    end
    unique case (state)
      S_CMP: begin
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (hit) begin
            cell_op[i] = pos_oh_c[i] ? OP_MERGE : OP_HOLD;
          end else if (!full) begin
            if (pos_oh_c[i]) begin
              cell_op[i] = OP_LOAD;
            end else if (!before_vec[i]) begin
              cell_op[i] = OP_LEFT;
            end
          end
        end
      end
      S_COLLAPSE: begin
        // grown range swallows its right neighbour, the rest close up
        for (int i = 0; i < MAX_RANGES; i++) begin
          if (absorb) begin
            if (pos_oh[i]) begin
              cell_op[i] = OP_ABSORB;
            end else if (above_q[i]) begin
              cell_op[i] = OP_RIGHT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      exp_start <= '0;
      exp_end   <= OFFSET_BITS'(EXP_END_RESET);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_EXP_START: exp_start <= cfg_data;
          REG_EXP_END:   exp_end   <= cfg_data;
          default: begin
          end
        endcase
      end

      unique case (state) inside
        S_IDLE, S_REPORT: begin
          if (accept) begin
            if (pkt_start > pkt_end) begin
              status_q <= ST_REJECTED;
              state    <= S_REPORT;
            end else begin
              ps_q  <= pkt_start;
              pe_q  <= pkt_end;
              state <= S_CMP;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          pos_oh  <= pos_oh_c;
          above_q <= ~before_vec & ~pos_oh_c;
          state   <= S_REPORT;
          if (hit) begin
            status_q <= ST_ACCEPTED;
            if (more) begin
              state <= S_COLLAPSE;
            end
          end else if (full) begin
            status_q <= ST_DROPPED;
          end else begin
            status_q <= ST_ACCEPTED;
            count    <= count + CNT_W'(1);
          end
        end
        S_COLLAPSE: begin
          if (absorb) begin
            count <= count - CNT_W'(1);
          end else begin
            state <= S_REPORT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid = (state == S_REPORT);
  assign status       = status_q;
  assign range_count  = count;
  assign complete     = (count == CNT_W'(1)) && (cell_start[0] == exp_start) &&
                        (cell_end[0] == exp_end);

endmodule

`default_nettype wire

// ===== rtl/rrmt_checker.sv =====
// ----------------------------------------------------------------------------
// rrmt_checker
// port-level checks on the range merge tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "received_range_merge_tracker_unit_defines.svh"

module rrmt_checker
  import rrmt_pkg::*;
#(
  parameter int MAX_RANGES  = DEF_MAX_RANGES,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  localparam int CNT_W      = $clog2(MAX_RANGES + 1)
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [OFFSET_BITS-1:0] pkt_start,
  input wire logic [OFFSET_BITS-1:0] pkt_end,
  input wire logic                   result_valid,
  input wire logic [STATUS_W-1:0]    status,
  input wire logic [CNT_W-1:0]       range_count,
  input wire logic                   complete
);

  // a reversed packet is answered on the very next cycle
  `RRMT_ASSERT_NEXT(a_reject_next, !rst && start && !busy && (pkt_start > pkt_end),
    result_valid && (status == ST_REJECTED), "reversed packet not rejected next cycle")

  `RRMT_ASSERT_NOW(a_drop_full, result_valid && (status == ST_DROPPED),
    range_count == CNT_W'(MAX_RANGES), "drop reported with table not full")

  `RRMT_ASSERT_NOW(a_complete_one, result_valid && complete,
    range_count == CNT_W'(1), "complete with range count other than one")

  `RRMT_ASSERT_NOW(a_count_bound, result_valid,
    (range_count <= CNT_W'(MAX_RANGES)) && !busy, "range count beyond table or busy result")

endmodule

bind received_range_merge_tracker_unit rrmt_checker #(
  .MAX_RANGES  (MAX_RANGES),
  .OFFSET_BITS (OFFSET_BITS)
) u_rrmt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .pkt_start    (pkt_start),
  .pkt_end      (pkt_end),
  .result_valid (result_valid),
  .status       (status),
  .range_count  (range_count),
  .complete     (complete)
);

`default_nettype wire
